>>> rtl/core/ccfit_pkg.sv
package ccfit_pkg;

  // fixed widths of the result fields
  localparam int unsigned CenterW   = 32;
  localparam int unsigned RadiusW   = 32;
  localparam int unsigned ResidualW = 48;

  // commands
  typedef enum logic {
    CMD_FIT  = 1'b0,
    CMD_DIST = 1'b1
  } cmd_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture request, start products
    logic mul_step;  // advance shared multiplier sequence
    logic div_start; // start a division
    logic div_sel_y; // division for y centre
    logic div_step;  // one division bit
    logic sqrt_start;
    logic sqrt_step;
    logic commit_fit;
    logic commit_deg;
    logic commit_dist;
  } ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic is_dist;
    logic mul_done;
    logic det_zero;
    logic div_done;
    logic sqrt_done;
  } stat_t;

endpackage

>>> rtl/core/ccfit_if.sv
interface ccfit_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] p1_x;
  logic signed [COORD_BITS-1:0] p1_y;
  logic signed [COORD_BITS-1:0] p2_x;
  logic signed [COORD_BITS-1:0] p2_y;
  logic signed [COORD_BITS-1:0] p3_x;
  logic signed [COORD_BITS-1:0] p3_y;

  modport source (output valid, cmd, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, input ready);
  modport sink (input valid, cmd, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, output ready);
endinterface

interface ccfit_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ccfit_pkg::CenterW-1:0] center_x_out;
  logic signed [ccfit_pkg::CenterW-1:0] center_y_out;
  logic [ccfit_pkg::RadiusW-1:0]      radius_out;
  logic [ccfit_pkg::ResidualW-1:0]    residual;
  logic                               degenerate;

  modport source (output valid, center_x_out, center_y_out, radius_out, residual, degenerate,
                  input ready);
  modport sink (input valid, center_x_out, center_y_out, radius_out, residual, degenerate,
                output ready);
endinterface

>>> rtl/core/ccfit_ctrl.sv
module ccfit_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ccfit_pkg::stat_t stat_i,
  output ccfit_pkg::ctrl_t ctrl_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_DIVX = 8'b0000_0100,
    S_DIVY = 8'b0000_1000,
    S_SQRT = 8'b0001_0000,
    S_DONE = 8'b0010_0000,
    S_DIST = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_busy;

  // result held until taken; new request only when output free
  assign out_busy    = (state_q == S_OUT) && !out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) || ((state_q == S_OUT) && out_ready_i);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE, S_OUT: begin
        if (!out_busy && in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_MUL;
        end else if (state_q == S_OUT && out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        ctrl_o.mul_step = 1'b1;
        if (stat_i.mul_done) begin
          if (stat_i.is_dist) begin
            state_d = S_DIST;
          end else if (stat_i.det_zero) begin
            ctrl_o.commit_deg = 1'b1;
            state_d           = S_OUT;
          end else begin
            ctrl_o.div_start = 1'b1;
            state_d          = S_DIVX;
          end
        end
      end
      S_DIVX: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          ctrl_o.div_start = 1'b1;
          ctrl_o.div_sel_y = 1'b1;
          state_d          = S_DIVY;
        end
      end
      S_DIVY: begin
        ctrl_o.div_step  = 1'b1;
        ctrl_o.div_sel_y = 1'b1;
        if (stat_i.div_done) begin
          ctrl_o.sqrt_start = 1'b1;
          state_d           = S_SQRT;
        end
      end
      S_SQRT: begin
        ctrl_o.sqrt_step = 1'b1;
        if (stat_i.sqrt_done) state_d = S_DONE;
      end
      S_DONE: begin
        ctrl_o.commit_fit = 1'b1;
        state_d           = S_OUT;
      end
      S_DIST: begin
        ctrl_o.commit_dist = 1'b1;
        state_d            = S_OUT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

>>> rtl/core/ccfit_dp.sv
module ccfit_dp #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ccfit_pkg::ctrl_t                     ctrl_i,
  output ccfit_pkg::stat_t                     stat_o,
  input  logic                                 cmd_i,
  input  logic signed [COORD_BITS-1:0]         ax_i,
  input  logic signed [COORD_BITS-1:0]         ay_i,
  input  logic signed [COORD_BITS-1:0]         bx_i,
  input  logic signed [COORD_BITS-1:0]         by_i,
  input  logic signed [COORD_BITS-1:0]         cx_i,
  input  logic signed [COORD_BITS-1:0]         cy_i,
  output logic signed [ccfit_pkg::CenterW-1:0] center_x_o,
  output logic signed [ccfit_pkg::CenterW-1:0] center_y_o,
  output logic [ccfit_pkg::RadiusW-1:0]        radius_o,
  output logic [ccfit_pkg::ResidualW-1:0]      residual_o,
  output logic                                 degenerate_o
);

  localparam int unsigned CW   = ccfit_pkg::CenterW;
  localparam int unsigned RW   = ccfit_pkg::RadiusW;
  localparam int unsigned SW   = ccfit_pkg::ResidualW;
  localparam int unsigned DW   = COORD_BITS + 1;          // coordinate difference
  localparam int unsigned QW   = 2 * COORD_BITS + 1;      // squared norm (unsigned)
  localparam int unsigned MW   = QW + 3;                  // signed multiplier operand
  localparam int unsigned PW   = 2 * MW;                  // signed product
  localparam int unsigned NW   = QW + DW + 3 + FRAC_BITS; // scaled numerator magnitude
  localparam int unsigned DETW = 2 * DW + 3;              // determinant magnitude
  localparam int unsigned NBW  = $clog2(NW + 1);
  // distance offset magnitude: scaled point or centre, plus headroom
  localparam int unsigned OW   = ((COORD_BITS + FRAC_BITS) > CW ?
                                  (COORD_BITS + FRAC_BITS) : CW) + 2;
  localparam int unsigned ODW  = OW + 1;                  // magnitude of offset plus sign
  localparam int unsigned SQW  = 2 * OW + 1;              // sum of squares
  localparam int unsigned RTW  = OW + 1;                  // root bits
  localparam int unsigned RBW  = $clog2(RTW + 1);

  // model state
  logic signed [CW-1:0] cx_q, cy_q;
  logic [RW-1:0]        rad_q;
  logic [SW-1:0]        res_q;
  logic                 deg_q;

  // captured request
  logic                 dist_q;
  logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q, cxp_q, cyp_q;

  // shared multiplier sequence: step index
  logic [3:0]               mstep_q;
  logic signed [MW-1:0]     ma, mb;
  logic signed [PW-1:0]     mp_q;
  logic signed [PW+2:0]     acc0_q, acc1_q, acc2_q;
  logic [QW-1:0]            a2_q, b2_q, c2_q;

  logic signed [DW-1:0] dbc, dca, dab, dcb, dac, dba;
  assign dbc = DW'(by_q) - DW'(cyp_q);
  assign dca = DW'(cyp_q) - DW'(ay_q);
  assign dab = DW'(ay_q) - DW'(by_q);
  assign dcb = DW'(cxp_q) - DW'(bx_q);
  assign dac = DW'(ax_q) - DW'(cxp_q);
  assign dba = DW'(bx_q) - DW'(ax_q);

  // fixed point offsets of first point from centre
  logic signed [ODW:0] offx, offy;
  assign offx = ($signed({{(ODW+1-COORD_BITS){ax_q[COORD_BITS-1]}}, ax_q}) <<< FRAC_BITS)
                - (ODW+1)'(cx_q);
  assign offy = ($signed({{(ODW+1-COORD_BITS){ay_q[COORD_BITS-1]}}, ay_q}) <<< FRAC_BITS)
                - (ODW+1)'(cy_q);

  // operand select for each step; the product is registered in mp_q on the next cycle
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (mstep_q)
      4'd0:  begin ma = MW'(ax_q);  mb = MW'(ax_q);  end
      4'd1:  begin ma = MW'(ay_q);  mb = MW'(ay_q);  end
      4'd2:  begin ma = MW'(bx_q);  mb = MW'(bx_q);  end
      4'd3:  begin ma = MW'(by_q);  mb = MW'(by_q);  end
      4'd4:  begin ma = MW'(cxp_q); mb = MW'(cxp_q); end
      4'd5:  begin ma = MW'(cyp_q); mb = MW'(cyp_q); end
      4'd6:  begin ma = MW'(ax_q);  mb = MW'(dbc);   end
      4'd7:  begin ma = MW'(bx_q);  mb = MW'(dca);   end
      4'd8:  begin ma = MW'(cxp_q); mb = MW'(dab);   end
      4'd9:  begin ma = $signed(MW'(a2_q)); mb = MW'(dbc); end
      4'd10: begin ma = $signed(MW'(b2_q)); mb = MW'(dca); end
      4'd11: begin ma = $signed(MW'(c2_q)); mb = MW'(dab); end
      4'd12: begin ma = $signed(MW'(a2_q)); mb = MW'(dcb); end
      4'd13: begin ma = $signed(MW'(b2_q)); mb = MW'(dac); end
      4'd14: begin ma = $signed(MW'(c2_q)); mb = MW'(dba); end
      default: begin ma = MW'(offx); mb = MW'(offy); end
    endcase
  end

  // dist request uses step 15; sq_q registers dx*dx + dy*dy from separate squarers
  logic [SQW:0]  sq_q;
  logic [ODW-1:0] mgx, mgy;
  logic [2*ODW-1:0] sqx, sqy;
  assign mgx = offx[ODW] ? ODW'(-offx) : ODW'(offx);
  assign mgy = offy[ODW] ? ODW'(-offy) : ODW'(offy);
  assign sqx = mgx * mgx;
  assign sqy = mgy * mgy;

  logic [3:0] mstep_prev_q;
  logic       mvalid_q, mdone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstep_q      <= '0;
      mvalid_q     <= 1'b0;
      mdone_q      <= 1'b0;
      mstep_prev_q <= '0;
    end else if (ctrl_i.load) begin
      mstep_q  <= (cmd_i == ccfit_pkg::CMD_DIST) ? 4'd15 : 4'd0;
      mvalid_q <= 1'b0;
      mdone_q  <= 1'b0;
    end else if (ctrl_i.mul_step) begin
      mvalid_q     <= !mdone_q && (mstep_q != 4'd15 || !mvalid_q);
      mstep_prev_q <= mstep_q;
      if (mstep_q != 4'd15 && mstep_q != 4'd14) mstep_q <= mstep_q + 4'd1;
      if (mvalid_q && (mstep_prev_q == 4'd14 || mstep_prev_q == 4'd15)) mdone_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      dist_q <= cmd_i;
      ax_q <= ax_i; ay_q <= ay_i; bx_q <= bx_i;
      by_q <= by_i; cxp_q <= cx_i; cyp_q <= cy_i;
      acc0_q <= '0; acc1_q <= '0; acc2_q <= '0;
      a2_q <= '0; b2_q <= '0; c2_q <= '0;
    end else if (ctrl_i.mul_step) begin
      mp_q <= ma * mb;
      sq_q <= (SQW+1)'(sqx) + (SQW+1)'(sqy);
      if (mvalid_q && !mdone_q) begin
        unique case (mstep_prev_q)
          4'd0, 4'd1: a2_q <= a2_q + QW'(mp_q);
          4'd2, 4'd3: b2_q <= b2_q + QW'(mp_q);
          4'd4, 4'd5: c2_q <= c2_q + QW'(mp_q);
          4'd6, 4'd7, 4'd8: acc0_q <= acc0_q + (PW+3)'(mp_q);
          4'd9, 4'd10, 4'd11: acc1_q <= acc1_q + (PW+3)'(mp_q);
          4'd12, 4'd13, 4'd14: acc2_q <= acc2_q + (PW+3)'(mp_q);
          default: ;
        endcase
      end
    end
  end

  logic signed [DETW-1:0] det;
  assign det = DETW'(acc0_q) <<< 1;

  // shared restoring divider, one quotient bit a cycle
  logic [NW-1:0]   dnum_q;
  logic [DETW-1:0] drem_q;
  logic [NW-1:0]   dquo_q;
  logic [NBW-1:0]  dcnt_q;
  logic            dneg_q;
  logic [DETW-1:0] dmag;
  logic signed [PW+2+FRAC_BITS:0] nsc;
  logic [DETW:0]   dtry;
  logic            ddone;

  assign dmag  = det[DETW-1] ? DETW'(-det) : DETW'(det);
  assign nsc   = (ctrl_i.div_sel_y ? (PW+3+FRAC_BITS)'(acc2_q) : (PW+3+FRAC_BITS)'(acc1_q))
                 <<< FRAC_BITS;
  assign dtry  = {drem_q, dnum_q[NW-1]};
  assign ddone = (dcnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      dnum_q <= nsc[PW+2+FRAC_BITS] ? NW'(-nsc) : NW'(nsc);
      dneg_q <= nsc[PW+2+FRAC_BITS] ^ det[DETW-1];
      drem_q <= '0;
      dquo_q <= '0;
      dcnt_q <= NBW'(NW);
    end else if (ctrl_i.div_step && !ddone) begin
      dnum_q <= dnum_q << 1;
      dcnt_q <= dcnt_q - 1'b1;
      if (dtry >= {1'b0, dmag}) begin
        drem_q <= DETW'(dtry - {1'b0, dmag});
        dquo_q <= {dquo_q[NW-2:0], 1'b1};
      end else begin
        drem_q <= dtry[DETW-1:0];
        dquo_q <= {dquo_q[NW-2:0], 1'b0};
      end
    end
  end

  // signed saturation of quotient
  logic [NW+CW-1:0]     dqw;
  logic signed [CW-1:0] qsat;
  logic                 qbig;
  assign dqw = (NW+CW)'(dquo_q);
  always_comb begin
    qbig = |(dqw >> (CW - 1));
    if (dneg_q) begin
      if (dqw > (NW+CW)'(33'h080000000)) qsat = {1'b1, {(CW-1){1'b0}}};
      else                               qsat = CW'(-dqw);
    end else begin
      qsat = qbig ? {1'b0, {(CW-1){1'b1}}} : CW'(dqw);
    end
  end

  logic signed [CW-1:0] ncx_q, ncy_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_step && ddone && !ctrl_i.div_start) begin
      if (ctrl_i.div_sel_y) ncy_q <= qsat;
      else                  ncx_q <= qsat;
    end else if (ctrl_i.div_start && ctrl_i.div_sel_y) begin
      ncx_q <= qsat;
    end else if (ctrl_i.sqrt_start) begin
      ncy_q <= qsat;
    end
  end

  // new centre offset from first point, squared distance for root
  logic signed [ODW:0] nox, noy;
  logic [ODW-1:0]      nmx, nmy;
  assign nox = ($signed({{(ODW+1-COORD_BITS){ax_q[COORD_BITS-1]}}, ax_q}) <<< FRAC_BITS)
               - (ODW+1)'(ncx_q);
  assign noy = ($signed({{(ODW+1-COORD_BITS){ay_q[COORD_BITS-1]}}, ay_q}) <<< FRAC_BITS)
               - (ODW+1)'(qsat);
  assign nmx = nox[ODW] ? ODW'(-nox) : ODW'(nox);
  assign nmy = noy[ODW] ? ODW'(-noy) : ODW'(noy);

  // bitwise square root, one bit a cycle
  logic [2*RTW-1:0] sv_q;
  logic [RTW-1:0]   root_q;
  logic [RBW-1:0]   rcnt_q;
  logic [RTW-1:0]   rc;
  logic [2*RTW-1:0] rsq;
  logic             rdone;
  logic [RBW-1:0]   rbit;
  assign rdone = (rcnt_q == '0);
  assign rbit  = rcnt_q - 1'b1;
  assign rc    = root_q | (RTW'(1) << rbit);
  assign rsq   = rc * rc;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sqrt_start) begin
      sv_q   <= (2*RTW)'(nmx * nmx) + (2*RTW)'(nmy * nmy);
      root_q <= '0;
      rcnt_q <= RBW'(RTW);
    end else if (ctrl_i.sqrt_step && !rdone) begin
      rcnt_q <= rbit;
      if (sv_q >= rsq) root_q <= rc;
    end
  end

  // residual against current radius
  logic [2*RW-1:0] rr;
  logic [SQW+1:0]  rdiff;
  assign rr    = rad_q * rad_q;
  assign rdiff = (SQW+2)'(sq_q) - (SQW+2)'(rr);

  logic [SQW+1:0] rabs;
  assign rabs = rdiff[SQW+1] ? -rdiff : rdiff;

  // model update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      rad_q <= RW'(1) << FRAC_BITS;
    end else if (ctrl_i.commit_fit) begin
      cx_q  <= ncx_q;
      cy_q  <= ncy_q;
      rad_q <= (|(root_q >> RW)) ? '1 : RW'(root_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit_fit) begin
      res_q <= '0;
      deg_q <= 1'b0;
    end else if (ctrl_i.commit_deg) begin
      res_q <= '0;
      deg_q <= 1'b1;
    end else if (ctrl_i.commit_dist) begin
      res_q <= (|(rabs >> SW)) ? '1 : SW'(rabs);
      deg_q <= 1'b0;
    end
  end

  assign stat_o.is_dist   = dist_q;
  assign stat_o.mul_done  = mdone_q;
  assign stat_o.det_zero  = (det == '0);
  assign stat_o.div_done  = ddone;
  assign stat_o.sqrt_done = rdone;

  assign center_x_o   = cx_q;
  assign center_y_o   = cy_q;
  assign radius_o     = rad_q;
  assign residual_o   = res_q;
  assign degenerate_o = deg_q;

endmodule

>>> rtl/core/circumcircle_fit_and_point_distance.sv
// circumcircle fit and point distance
// distance request: runs the product sequence, then commits the residual
// fit request: the 15-step product sequence, two 61-bit serial divisions and a 35-bit
//   serial root at the default widths; collinear points stop after the products, flagged degenerate
// one request at a time; the next is taken in the cycle its result is taken
// reset (asynchronous, active low): centre 0, radius 1.0, no result pending
module circumcircle_fit_and_point_distance #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ccfit_in_if.sink    in_i,
  ccfit_out_if.source out_o
);

  ccfit_pkg::ctrl_t ctrl;
  ccfit_pkg::stat_t stat;

  ccfit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  ccfit_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .cmd_i        (in_i.cmd),
    .ax_i         (in_i.p1_x),
    .ay_i         (in_i.p1_y),
    .bx_i         (in_i.p2_x),
    .by_i         (in_i.p2_y),
    .cx_i         (in_i.p3_x),
    .cy_i         (in_i.p3_y),
    .center_x_o   (out_o.center_x_out),
    .center_y_o   (out_o.center_y_out),
    .radius_o     (out_o.radius_out),
    .residual_o   (out_o.residual),
    .degenerate_o (out_o.degenerate)
  );

endmodule

>>> dv/circumcircle_fit_and_point_distance_tb.sv
module circumcircle_fit_and_point_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = 16;
  localparam int unsigned FB = 8;
  localparam int unsigned NumRandom = 500;
  localparam int unsigned HoldCycles = 400;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    ccfit_pkg::cmd_e cmd;
    coord_t          ax, ay, bx, by, cx, cy;
  } circ_req_t;

  typedef struct {
    logic signed [ccfit_pkg::CenterW-1:0] cx;
    logic signed [ccfit_pkg::CenterW-1:0] cy;
    logic [ccfit_pkg::RadiusW-1:0]        rad;
    logic [ccfit_pkg::ResidualW-1:0]      res;
    logic                                 deg;
  } circ_res_t;

  // directed row: request plus optional typed-in result
  typedef struct {
    circ_req_t req;
    bit        typed;
    circ_res_t res;
  } circ_row_t;

  logic clk_i;
  logic rst_ni;

  ccfit_in_if #(.COORD_BITS(CB)) in_if ();
  ccfit_out_if                   out_if ();

  circumcircle_fit_and_point_distance #(
    .COORD_BITS(CB),
    .FRAC_BITS (FB)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // model of the circle held by the block
  logic signed [63:0] mdl_cx, mdl_cy;
  logic [63:0]        mdl_rad;

  circ_res_t pending_res[$];
  int        n_fail = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic signed [63:0] clip32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return v[63:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [127:0] v);
    logic [63:0]  acc;
    logic [127:0] c;
    acc = '0;
    for (int b = 63; b >= 0; b--) begin
      c = {64'd0, acc | (64'd1 << b)};
      if (c * c <= v) acc = c[63:0];
    end
    return acc;
  endfunction

  function automatic logic [127:0] dist_sq(input coord_t px, input coord_t py);
    logic signed [127:0] dx, dy;
    dx = (128'(signed'(px)) <<< FB) - 128'(mdl_cx);
    dy = (128'(signed'(py)) <<< FB) - 128'(mdl_cy);
    return dx * dx + dy * dy;
  endfunction

  // predicts the result of one request and updates the circle model
  function automatic circ_res_t circle_predict(input circ_req_t r);
    logic signed [127:0] ax, ay, bx, by, cx, cy, det, a2, b2, c2, nx, ny, diff;
    logic [127:0] root;
    circ_res_t o;
    ax = r.ax; ay = r.ay; bx = r.bx; by = r.by; cx = r.cx; cy = r.cy;
    o.res = '0;
    o.deg = 1'b0;
    if (r.cmd == ccfit_pkg::CMD_FIT) begin
      det = 2 * (ax * (by - cy) + bx * (cy - ay) + cx * (ay - by));
      if (det == 0) begin
        o.deg = 1'b1;
      end else begin
        a2 = ax * ax + ay * ay;
        b2 = bx * bx + by * by;
        c2 = cx * cx + cy * cy;
        nx = a2 * (by - cy) + b2 * (cy - ay) + c2 * (ay - by);
        ny = a2 * (cx - bx) + b2 * (ax - cx) + c2 * (bx - ax);
        mdl_cx = clip32((nx <<< FB) / det);
        mdl_cy = clip32((ny <<< FB) / det);
        root = floor_root(dist_sq(r.ax, r.ay));
        mdl_rad = (root > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : root[63:0];
      end
    end else begin
      diff = signed'(dist_sq(r.ax, r.ay)) - signed'(128'(mdl_rad) * 128'(mdl_rad));
      if (diff < 0) diff = -diff;
      o.res = (diff > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : diff[47:0];
    end
    o.cx  = mdl_cx[31:0];
    o.cy  = mdl_cy[31:0];
    o.rad = mdl_rad[31:0];
    return o;
  endfunction

  function automatic void field_chk(input string nm, input logic [63:0] exp_v,
                                    input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0h, got %0h", $time, nm, exp_v, act_v);
      n_fail++;
    end
  endfunction

  // result side: random ready, one long hold-off on request
  int unsigned hold_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= 0;
    end else if (hold_req && hold_cnt < HoldCycles) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= hold_cnt + 1;
    end else begin
      out_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 19);
    end
  end

  // compare each returned result with the oldest expectation
  always @(posedge clk_i) begin
    circ_res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t unexpected result: expected none, got cx %0h", $time,
                 out_if.center_x_out);
        n_fail++;
      end else begin
        e = pending_res.pop_front();
        field_chk("center_x", 64'(e.cx), 64'(out_if.center_x_out));
        field_chk("center_y", 64'(e.cy), 64'(out_if.center_y_out));
        field_chk("radius", 64'(e.rad), 64'(out_if.radius_out));
        field_chk("residual", 64'(e.res), 64'(out_if.residual));
        field_chk("degenerate", 64'(e.deg), 64'(out_if.degenerate));
      end
    end
  end

  // offer one request and wait for its handshake
  task automatic send_req(input circ_req_t r, input bit typed, input circ_res_t tr);
    circ_res_t p;
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= r.cmd;
    in_if.p1_x  <= r.ax;
    in_if.p1_y  <= r.ay;
    in_if.p2_x  <= r.bx;
    in_if.p2_y  <= r.by;
    in_if.p3_x  <= r.cx;
    in_if.p3_y  <= r.cy;
    do @(posedge clk_i); while (!in_if.ready);
    p = circle_predict(r);
    pending_res.push_back(typed ? tr : p);
  endtask

  function automatic coord_t rand_coord();
    if ($urandom_range(0, 3) == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 400)) - 16'sd200;
  endfunction

  function automatic circ_req_t mk_req(input ccfit_pkg::cmd_e c, input int ax, input int ay,
                                       input int bx, input int by, input int cx,
                                       input int cy);
    circ_req_t r;
    r.cmd = c;
    r.ax = coord_t'(ax); r.ay = coord_t'(ay); r.bx = coord_t'(bx);
    r.by = coord_t'(by); r.cx = coord_t'(cx); r.cy = coord_t'(cy);
    return r;
  endfunction

  function automatic circ_res_t mk_res(input int cx, input int cy, input int rad,
                                       input longint res, input bit deg);
    circ_res_t o;
    o.cx = cx; o.cy = cy; o.rad = rad; o.res = 48'(res); o.deg = deg;
    return o;
  endfunction

  circ_row_t dir_rows[$];
  circ_res_t no_res;

  initial begin
    circ_req_t r;
    int        k;
    in_if.valid = 1'b0;
    in_if.cmd   = ccfit_pkg::CMD_FIT;
    in_if.p1_x  = '0;
    in_if.p1_y  = '0;
    in_if.p2_x  = '0;
    in_if.p2_y  = '0;
    in_if.p3_x  = '0;
    in_if.p3_y  = '0;
    mdl_cx  = '0;
    mdl_cy  = '0;
    mdl_rad = 64'd1 << FB;
    no_res  = mk_res(0, 0, 0, 0, 1'b0);
    rst_ni  = 1'b0;

    // directed table: reset state, degenerate fits, extremes, saturation
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_DIST, 0, 0, 5, 5, 5, 5), 1'b1,
                         mk_res(0, 0, 256, 65536, 1'b0)});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_DIST, 1, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(0, 0, 256, 0, 1'b0)});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_FIT, 3, 3, 3, 3, 3, 3), 1'b1,
                         mk_res(0, 0, 256, 0, 1'b1)});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_FIT, 0, 0, 2, 2, 9, 9), 1'b1,
                         mk_res(0, 0, 256, 0, 1'b1)});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_DIST, -32768, -32768, 0, 0, 0, 0), 1'b0,
                         no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_DIST, 32767, 32767, 0, 0, 0, 0), 1'b0,
                         no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_FIT, 1, 0, -1, 0, 0, 1), 1'b0, no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_DIST, 0, -1, 0, 0, 0, 0), 1'b0, no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_FIT, 0, 0, 3, 0, 0, 7), 1'b0, no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_FIT, -32768, -32768, 32767, -32768, -32768,
                                32767), 1'b0, no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_DIST, 32767, -32768, 0, 0, 0, 0), 1'b0,
                         no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_FIT, 32767, 32767, -32768, 32767, 32767,
                                -32768), 1'b0, no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_FIT, -32768, -32768, 32767, 32767, 32767,
                                32766), 1'b0, no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_DIST, -32768, -32768, 0, 0, 0, 0), 1'b0,
                         no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_FIT, -32768, 32767, 32767, -32768, 32766,
                                -32767), 1'b0, no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_DIST, 32767, 32767, 0, 0, 0, 0), 1'b0,
                         no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_FIT, -1, -1, 1, -1, 0, 1), 1'b0, no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_DIST, -1, -1, -32768, 32767, 0, 0), 1'b0,
                         no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_FIT, 2, 1, 4, 2, 8, 4), 1'b0, no_res});
    dir_rows.push_back('{mk_req(ccfit_pkg::CMD_DIST, 100, -100, 0, 0, 0, 0), 1'b0, no_res});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    // random part: fits through random, collinear and wide points, probes near the circle and at random points
    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= 200 && n < 280);
      if (n == 120) hold_req = 1'b1;
      if (n == 350) begin
        in_if.valid <= 1'b0;
        wait (pending_res.size() == 0);
      end
      k = $urandom_range(0, 99);
      if (k < 25) begin
        r = mk_req(ccfit_pkg::CMD_FIT, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord());
        if (k < 4) begin
          r.cx = coord_t'(r.ax + 2 * (r.bx - r.ax));
          r.cy = coord_t'(r.ay + 2 * (r.by - r.ay));
        end
      end else begin
        r = mk_req(ccfit_pkg::CMD_DIST, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord());
        if (k < 70) begin
          r.ax = coord_t'(mdl_cx >>> FB) + coord_t'(mdl_rad >> FB)
                 + coord_t'($urandom_range(0, 6)) - 16'sd3;
          r.ay = coord_t'(mdl_cy >>> FB) + coord_t'($urandom_range(0, 6)) - 16'sd3;
        end
      end
      send_req(r, 1'b0, no_res);
    end
    in_if.valid <= 1'b0;
    calm = 1'b0;

    wait (pending_res.size() == 0);
    repeat (300) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // timeout
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
